// ===== hdl/cxs_pkg.sv =====
// Shared constants, types and command/status structs for the CoreXY step generator.
package cxs_pkg;

	localparam int STEP_COUNT_BITS = 17;
	localparam int PROFILE_BITS    = 24;
	localparam int STEP_IN_BITS    = 18;

	localparam logic [STEP_COUNT_BITS-1:0] COUNT_MAX = {STEP_COUNT_BITS{1'b1}};
	localparam logic [PROFILE_BITS-1:0]    PROF_MAX  = {PROFILE_BITS{1'b1}};

	// divider and square root geometry
	localparam int DIV_NUM_W  = 54;
	localparam int DIV_DEN_W  = 32;
	localparam int DIV_ITERS  = 54;
	localparam int SQ_W       = 58;
	localparam int SQRT_ITERS = 29;
	localparam int RATE_W     = 29;
	localparam int CNT_W      = 6;
	localparam int T_W        = 41;

	// 500000^2 * 2^16, Q16 square of the rate numerator
	localparam logic [DIV_NUM_W-1:0] R0_NUM   = 54'd16384000000000000;
	// 500000 in Q8
	localparam logic [DIV_NUM_W-1:0] RATE_NUM = 54'd128000000;
	localparam logic [T_W-1:0]       T_SAT    = 41'h100_0000_0000;
	localparam logic [SQ_W-1:0]      SQRT_TOP = 58'h100_0000_0000_0000;

	// register map (word index)
	localparam logic [1:0] REG_FAST  = 2'd0;
	localparam logic [1:0] REG_START = 2'd1;
	localparam logic [1:0] REG_ACCEL = 2'd2;

	localparam logic [15:0] FAST_RST  = 16'd50;
	localparam logic [15:0] START_RST = 16'd600;
	localparam logic [16:0] ACCEL_RST = 17'd10000;

	typedef enum logic [1:0] {
		DSEL_R0   = 2'd0,
		DSEL_RMAX = 2'd1,
		DSEL_D    = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic     capture;
		logic     prep;
		logic     mul;
		logic     div_load;
		div_sel_t div_sel;
		logic     div_step;
		logic     sqrt_load;
		logic     sqrt_step;
		logic     commit;
	} cxs_cmd_t;

	typedef struct packed {
		logic needs_ramp;
	} cxs_stat_t;

endpackage

// ===== hdl/cxs_ifs.sv =====
// Valid/ready channel interfaces for step items and result words.
interface cxs_item_if;
	import cxs_pkg::*;
	logic                           valid;
	logic                           ready;
	logic                           cmd;
	logic signed [STEP_IN_BITS-1:0] a_steps;
	logic signed [STEP_IN_BITS-1:0] b_steps;
	logic                           restart_profile;
	logic [PROFILE_BITS-1:0]        profile_total;
	logic                           abort;

	modport source (output valid, cmd, a_steps, b_steps, restart_profile, profile_total, abort,
		input ready);
	modport sink (input valid, cmd, a_steps, b_steps, restart_profile, profile_total, abort,
		output ready);
endinterface

interface cxs_res_if;
	import cxs_pkg::*;
	logic                       valid;
	logic                       ready;
	logic                       step_a;
	logic                       step_b;
	logic                       dir_a;
	logic                       dir_b;
	logic [15:0]                half_period_us;
	logic [STEP_COUNT_BITS-1:0] completed_steps;
	logic                       done_res;
	logic                       aborted;

	modport source (output valid, step_a, step_b, dir_a, dir_b, half_period_us,
		completed_steps, done_res, aborted, input ready);
	modport sink (input valid, step_a, step_b, dir_a, dir_b, half_period_us,
		completed_steps, done_res, aborted, output ready);
endinterface

// ===== hdl/cxs_ctrl.sv =====
// Controller: sequences capture, ramp math, divider/sqrt iterations and commit.
module cxs_ctrl import cxs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  cxs_stat_t stat,
	output cxs_cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_PREP   = 8'b0000_0010,
		S_MUL    = 8'b0000_0100,
		S_DIV0   = 8'b0000_1000,
		S_SQRT   = 8'b0001_0000,
		S_DIV1   = 8'b0010_0000,
		S_DIV2   = 8'b0100_0000,
		S_COMMIT = 8'b1000_0000
	} state_t;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic               out_valid_q;
	logic               out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.div_sel = DSEL_R0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = stat.needs_ramp ? S_MUL : S_COMMIT;
			end
			S_MUL: begin
				cmd.mul      = 1'b1;
				cmd.div_load = 1'b1;
				cmd.div_sel  = DSEL_R0;
				cnt_d        = '0;
				state_d      = S_DIV0;
			end
			S_DIV0: begin
				if (cnt_q == CNT_W'(DIV_ITERS)) begin
					cmd.sqrt_load = 1'b1;
					cnt_d         = '0;
					state_d       = S_SQRT;
				end else begin
					cmd.div_step = 1'b1;
					cnt_d        = cnt_q + 1'b1;
				end
			end
			S_SQRT: begin
				if (cnt_q == CNT_W'(SQRT_ITERS)) begin
					cmd.div_load = 1'b1;
					cmd.div_sel  = DSEL_RMAX;
					cnt_d        = '0;
					state_d      = S_DIV1;
				end else begin
					cmd.sqrt_step = 1'b1;
					cnt_d         = cnt_q + 1'b1;
				end
			end
			S_DIV1: begin
				if (cnt_q == CNT_W'(DIV_ITERS)) begin
					cmd.div_load = 1'b1;
					cmd.div_sel  = DSEL_D;
					cnt_d        = '0;
					state_d      = S_DIV2;
				end else begin
					cmd.div_step = 1'b1;
					cnt_d        = cnt_q + 1'b1;
				end
			end
			S_DIV2: begin
				if (cnt_q == CNT_W'(DIV_ITERS)) begin
					state_d = S_COMMIT;
				end else begin
					cmd.div_step = 1'b1;
					cnt_d        = cnt_q + 1'b1;
				end
			end
			S_COMMIT: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== hdl/cxs_dp.sv =====
// Datapath: move state, Bresenham update, ramp limit, shared divider and square root.
module cxs_dp import cxs_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cxs_cmd_t                       cmd,
	output cxs_stat_t                      stat,
	// configuration
	input  logic [15:0]                    fast_delay_us,
	input  logic [15:0]                    start_delay_us,
	input  logic [16:0]                    accel_steps_per_s2,
	// input word fields
	input  logic                           in_cmd,
	input  logic signed [STEP_IN_BITS-1:0] in_a_steps,
	input  logic signed [STEP_IN_BITS-1:0] in_b_steps,
	input  logic                           in_restart,
	input  logic [PROFILE_BITS-1:0]        in_total,
	input  logic                           in_abort,
	// result word fields
	output logic                           step_a,
	output logic                           step_b,
	output logic                           dir_a,
	output logic                           dir_b,
	output logic [15:0]                    half_period_us,
	output logic [STEP_COUNT_BITS-1:0]     completed_steps,
	output logic                           done_res,
	output logic                           aborted
);

	// captured word
	logic                       cmd_q, restart_q, abort_q;
	logic [STEP_IN_BITS-1:0]    a_raw_q, b_raw_q;
	logic [PROFILE_BITS-1:0]    total_q;

	// move state
	logic [STEP_COUNT_BITS-1:0] a_count_q, b_count_q, move_len_q, done_cnt_q;
	logic [STEP_COUNT_BITS:0]   a_acc_q, b_acc_q;
	logic [PROFILE_BITS-1:0]    pos_q, plen_q;
	logic [1:0]                 dir_q;
	logic                       active_q;

	// math registers
	logic [15:0]                f_eff_q, s_eff_q;
	logic [PROFILE_BITS-1:0]    lim_q;
	logic [T_W-1:0]             t_q;
	logic [DIV_NUM_W-1:0]       num_q;
	logic [DIV_DEN_W-1:0]       rem_q, den_q;
	logic [SQ_W-1:0]            v_q, res_q, bit_q;
	logic [RATE_W-1:0]          r_q;

	assign stat.needs_ramp = cmd_q && active_q && !abort_q;

	// load-time decode of counts
	function automatic logic [STEP_COUNT_BITS-1:0] mag(input logic [STEP_IN_BITS-1:0] v);
		logic [STEP_IN_BITS-1:0] m;
		m = v[STEP_IN_BITS-1] ? (~v + 1'b1) : v;
		return m[STEP_IN_BITS-1] ? COUNT_MAX : m[STEP_COUNT_BITS-1:0];
	endfunction

	logic [STEP_COUNT_BITS-1:0] a_mag, b_mag, new_len;
	assign a_mag   = mag(a_raw_q);
	assign b_mag   = mag(b_raw_q);
	assign new_len = (a_mag > b_mag) ? a_mag : b_mag;

	// ramp limit: min(pos+1, len-pos) on clamped position, zero when len is zero
	logic [PROFILE_BITS-1:0] p_cl, from_c, to_c, lim_c;
	assign p_cl   = (pos_q < plen_q) ? pos_q : (plen_q - 1'b1);
	assign from_c = p_cl + 1'b1;
	assign to_c   = plen_q - p_cl;
	assign lim_c  = (plen_q == '0) ? '0 : ((from_c < to_c) ? from_c : to_c);

	// 2*A*L, saturated; operands widened so the full product is kept
	logic [T_W:0] t_full;
	assign t_full = ({(T_W+1-17)'(0), accel_steps_per_s2} *
		{(T_W+1-PROFILE_BITS)'(0), lim_q}) << 1;

	// capped rate and divider operands
	logic [RATE_W-1:0] r_cap;
	always_comb begin
		r_cap = (num_q < {(DIV_NUM_W-RATE_W)'(0), r_q}) ? num_q[RATE_W-1:0] : r_q;
		if (r_cap == '0)
			r_cap = RATE_W'(1);
	end

	logic [DIV_NUM_W-1:0] div_num_c;
	logic [DIV_DEN_W-1:0] div_den_c;
	always_comb begin
		case (cmd.div_sel)
			DSEL_R0: begin
				div_num_c = R0_NUM;
				div_den_c = s_eff_q * s_eff_q;
			end
			DSEL_RMAX: begin
				div_num_c = RATE_NUM;
				div_den_c = {(DIV_DEN_W-16)'(0), f_eff_q};
			end
			default: begin
				div_num_c = RATE_NUM + {(DIV_NUM_W-RATE_W+1)'(0), r_cap[RATE_W-1:1]};
				div_den_c = {(DIV_DEN_W-RATE_W)'(0), r_cap};
			end
		endcase
	end

	// restoring divide, one quotient bit per cycle
	logic [DIV_DEN_W:0] trial;
	logic               q_bit;
	assign trial = {rem_q, num_q[DIV_NUM_W-1]};
	assign q_bit = (trial >= {1'b0, den_q});

	// bitwise square root
	logic [SQ_W-1:0] sq_try;
	assign sq_try = res_q + bit_q;

	// step result
	logic [STEP_COUNT_BITS:0] a_sum, b_sum;
	logic [STEP_COUNT_BITS-1:0] done_inc;
	logic [DIV_NUM_W-1:0] d_lo;
	logic [15:0]          d_out;
	assign a_sum    = a_acc_q + {1'b0, a_count_q};
	assign b_sum    = b_acc_q + {1'b0, b_count_q};
	assign done_inc = done_cnt_q + 1'b1;
	assign d_lo     = (num_q < {(DIV_NUM_W-16)'(0), f_eff_q}) ? {(DIV_NUM_W-16)'(0), f_eff_q} : num_q;
	assign d_out    = (d_lo > {(DIV_NUM_W-16)'(0), s_eff_q}) ? s_eff_q : d_lo[15:0];

	// captured word and math registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q     <= in_cmd;
			a_raw_q   <= in_a_steps;
			b_raw_q   <= in_b_steps;
			restart_q <= in_restart;
			total_q   <= in_total;
			abort_q   <= in_abort;
		end
		if (cmd.prep) begin
			f_eff_q <= (fast_delay_us == '0) ? 16'd1 : fast_delay_us;
			s_eff_q <= (start_delay_us == '0) ? 16'd1 : start_delay_us;
			lim_q   <= lim_c;
		end
		if (cmd.mul)
			t_q <= (t_full > {1'b0, T_SAT}) ? T_SAT : t_full[T_W-1:0];
		if (cmd.div_load) begin
			num_q <= div_num_c;
			den_q <= div_den_c;
			rem_q <= '0;
			if (cmd.div_sel == DSEL_RMAX)
				r_q <= res_q[RATE_W-1:0];
		end else if (cmd.div_step) begin
			num_q <= {num_q[DIV_NUM_W-2:0], q_bit};
			rem_q <= q_bit ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
		end
		if (cmd.sqrt_load) begin
			v_q   <= {(SQ_W-DIV_NUM_W)'(0), num_q} + {1'b0, t_q, 16'd0};
			res_q <= '0;
			bit_q <= SQRT_TOP;
		end else if (cmd.sqrt_step) begin
			if (v_q >= sq_try) begin
				v_q   <= v_q - sq_try;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	// move state and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_count_q  <= '0;
			b_count_q  <= '0;
			a_acc_q    <= '0;
			b_acc_q    <= '0;
			move_len_q <= '0;
			done_cnt_q <= '0;
			pos_q      <= '0;
			plen_q     <= '0;
			dir_q      <= '0;
			active_q   <= 1'b0;
		end else if (cmd.commit) begin
			if (!cmd_q) begin
				dir_q      <= {~b_raw_q[STEP_IN_BITS-1], ~a_raw_q[STEP_IN_BITS-1]};
				a_count_q  <= a_mag;
				b_count_q  <= b_mag;
				move_len_q <= new_len;
				a_acc_q    <= '0;
				b_acc_q    <= '0;
				done_cnt_q <= '0;
				if (restart_q) begin
					pos_q  <= '0;
					plen_q <= total_q;
				end
				active_q <= (new_len != '0);
			end else if (active_q && abort_q) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				a_acc_q <= (a_sum >= {1'b0, move_len_q}) ? a_sum - {1'b0, move_len_q} : a_sum;
				b_acc_q <= (b_sum >= {1'b0, move_len_q}) ? b_sum - {1'b0, move_len_q} : b_sum;
				if (pos_q != PROF_MAX)
					pos_q <= pos_q + 1'b1;
				done_cnt_q <= done_inc;
				if (done_inc >= move_len_q)
					active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			step_a         <= 1'b0;
			step_b         <= 1'b0;
			half_period_us <= '0;
			aborted        <= 1'b0;
			if (!cmd_q) begin
				dir_a           <= ~a_raw_q[STEP_IN_BITS-1];
				dir_b           <= ~b_raw_q[STEP_IN_BITS-1];
				completed_steps <= '0;
				done_res        <= (new_len == '0);
			end else begin
				dir_a           <= dir_q[0];
				dir_b           <= dir_q[1];
				completed_steps <= done_cnt_q;
				done_res        <= 1'b1;
				if (active_q && abort_q) begin
					aborted <= 1'b1;
				end else if (active_q) begin
					step_a          <= (a_sum >= {1'b0, move_len_q});
					step_b          <= (b_sum >= {1'b0, move_len_q});
					half_period_us  <= d_out;
					completed_steps <= done_inc;
					done_res        <= (done_inc >= move_len_q);
				end
			end
		end
	end

endmodule

// ===== hdl/corexy_accel_step_generator_core.sv =====
// Top level: APB configuration registers, controller and datapath of the step generator.
//
// channel   dir  handshake      word
// step_in   in   valid/ready    cmd, a_steps, b_steps, restart_profile, profile_total, abort
// res_out   out  valid/ready    step_a, step_b, dir_a, dir_b, half_period_us,
//                               completed_steps, done_res, aborted
// apb       in   psel/penable   fast_delay_us, start_delay_us, accel_steps_per_s2
//
// A step word with an active move goes through capture, limit, multiply, a divide for the
// start rate, a square root, two more divides and commit. Load words, idle steps and aborts
// go from capture and prep straight to commit. The divides share one serial divider.
// One word is in work at a time; a finished result waits in the output register.
// arst_n clears move state and restores the register defaults.
module corexy_accel_step_generator_core import cxs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	cxs_item_if.sink    step_in,
	cxs_res_if.source   res_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0] fast_q, start_q;
	logic [16:0] accel_q;
	logic        wr_en;
	cxs_cmd_t    cmd;
	cxs_stat_t   stat;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_q  <= FAST_RST;
			start_q <= START_RST;
			accel_q <= ACCEL_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_FAST:  fast_q  <= pwdata[15:0];
				REG_START: start_q <= pwdata[15:0];
				REG_ACCEL: accel_q <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (paddr[3:2])
			REG_FAST:  prdata = {16'd0, fast_q};
			REG_START: prdata = {16'd0, start_q};
			REG_ACCEL: prdata = {15'd0, accel_q};
			default:   prdata = '0;
		endcase
	end

	cxs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (step_in.valid),
		.in_ready  (step_in.ready),
		.out_valid (res_out.valid),
		.out_ready (res_out.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	cxs_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.stat               (stat),
		.fast_delay_us      (fast_q),
		.start_delay_us     (start_q),
		.accel_steps_per_s2 (accel_q),
		.in_cmd             (step_in.cmd),
		.in_a_steps         (step_in.a_steps),
		.in_b_steps         (step_in.b_steps),
		.in_restart         (step_in.restart_profile),
		.in_total           (step_in.profile_total),
		.in_abort           (step_in.abort),
		.step_a             (res_out.step_a),
		.step_b             (res_out.step_b),
		.dir_a              (res_out.dir_a),
		.dir_b              (res_out.dir_b),
		.half_period_us     (res_out.half_period_us),
		.completed_steps    (res_out.completed_steps),
		.done_res           (res_out.done_res),
		.aborted            (res_out.aborted)
	);

endmodule

// ===== dv/cxs_step_checker.sv =====
`timescale 1ns / 100ps
// Checker for the step generator: tracks register writes, predicts every result word, compares.
module cxs_step_checker import cxs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	cxs_item_if         step_in,
	cxs_res_if          res_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic                       step_a;
		logic                       step_b;
		logic                       dir_a;
		logic                       dir_b;
		logic [15:0]                half_period_us;
		logic [STEP_COUNT_BITS-1:0] completed_steps;
		logic                       done_res;
		logic                       aborted;
	} step_res_t;

	// register shadow
	logic [15:0] fast_us, start_us;
	logic [16:0] accel;

	// move state shadow
	logic [STEP_COUNT_BITS-1:0] cnt_a, cnt_b, move_len, done_cnt;
	logic [STEP_COUNT_BITS:0]   acc_a, acc_b;
	logic [PROFILE_BITS-1:0]    prof_pos, prof_len;
	logic [1:0]                 dirs;
	logic                       active;

	step_res_t exp_words[$];

	assign pending = exp_words.size();

	function automatic logic [63:0] isqrt(input logic [63:0] v);
		logic [63:0] root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v    = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// half-period from the symmetric ramp at the current profile position
	function automatic logic [15:0] ramp_half_period();
		logic [63:0] f, s, lim, p, t, r, rmax, d;
		f   = (fast_us == 0) ? 64'd1 : 64'(fast_us);
		s   = (start_us == 0) ? 64'd1 : 64'(start_us);
		lim = 0;
		if (prof_len != 0) begin
			p   = (prof_pos < prof_len) ? 64'(prof_pos) : 64'(prof_len) - 1;
			lim = (p + 1 < 64'(prof_len) - p) ? p + 1 : 64'(prof_len) - p;
		end
		t = 2 * 64'(accel) * lim;
		if (t > 64'd1 << 40) t = 64'd1 << 40;
		r    = isqrt(64'd16384000000000000 / (s * s) + (t << 16));
		rmax = 64'd128000000 / f;
		if (r > rmax) r = rmax;
		if (r == 0) r = 1;
		d = (64'd128000000 + (r >> 1)) / r;
		if (d < f) d = f;
		if (d > s) d = s;
		return d[15:0];
	endfunction

	function automatic logic [STEP_COUNT_BITS-1:0] count_mag(input logic [STEP_IN_BITS-1:0] v);
		logic [STEP_IN_BITS:0] m;
		m = v[STEP_IN_BITS-1] ? (19'h40000 - 19'(v)) : 19'(v);
		return (m > 19'(COUNT_MAX)) ? COUNT_MAX : m[STEP_COUNT_BITS-1:0];
	endfunction

	// advance the shadow state by one word and return the result it produces
	function automatic step_res_t predict_word(input logic cmd, input logic [17:0] as,
			input logic [17:0] bs, input logic restart, input logic [23:0] total,
			input logic abort);
		step_res_t w;
		w = '0;
		if (!cmd) begin
			dirs     = {~bs[17], ~as[17]};
			cnt_a    = count_mag(as);
			cnt_b    = count_mag(bs);
			move_len = (cnt_a > cnt_b) ? cnt_a : cnt_b;
			acc_a    = 0;
			acc_b    = 0;
			done_cnt = 0;
			if (restart) begin
				prof_pos = 0;
				prof_len = total;
			end
			active     = move_len != 0;
			w.done_res = !active;
		end else if (!active) begin
			w.done_res = 1'b1;
		end else if (abort) begin
			active     = 1'b0;
			w.done_res = 1'b1;
			w.aborted  = 1'b1;
		end else begin
			w.half_period_us = ramp_half_period();
			acc_a = acc_a + cnt_a;
			acc_b = acc_b + cnt_b;
			if (acc_a >= move_len) begin
				w.step_a = 1'b1;
				acc_a    = acc_a - move_len;
			end
			if (acc_b >= move_len) begin
				w.step_b = 1'b1;
				acc_b    = acc_b - move_len;
			end
			if (prof_pos < PROF_MAX) prof_pos++;
			done_cnt++;
			if (done_cnt >= move_len) active = 1'b0;
			w.done_res = !active;
		end
		w.dir_a           = dirs[0];
		w.dir_b           = dirs[1];
		w.completed_steps = done_cnt;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		step_res_t got, want;
		if (!arst_n) begin
			fast_us  <= FAST_RST;
			start_us <= START_RST;
			accel    <= ACCEL_RST;
			cnt_a    <= '0;
			cnt_b    <= '0;
			move_len <= '0;
			done_cnt <= '0;
			acc_a    <= '0;
			acc_b    <= '0;
			prof_pos <= '0;
			prof_len <= '0;
			dirs     <= '0;
			active   <= 1'b0;
			errors   <= 0;
			exp_words.delete();
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_FAST:  fast_us  = pwdata[15:0];
					REG_START: start_us = pwdata[15:0];
					REG_ACCEL: accel    = pwdata[16:0];
					default: ;
				endcase
			end
			// accepted input words
			if (step_in.valid && step_in.ready)
				exp_words.push_back(predict_word(step_in.cmd, step_in.a_steps,
					step_in.b_steps, step_in.restart_profile, step_in.profile_total,
					step_in.abort));
			// accepted result words
			if (res_out.valid && res_out.ready) begin
				got = '{res_out.step_a, res_out.step_b, res_out.dir_a, res_out.dir_b,
					res_out.half_period_us, res_out.completed_steps, res_out.done_res,
					res_out.aborted};
				if (exp_words.size() == 0) begin
					if (errors < 10)
						$display("%0t: result word with nothing expected: %p", $time, got);
					errors <= errors + 1;
				end else begin
					want = exp_words.pop_front();
					if (got.step_a !== want.step_a || got.step_b !== want.step_b ||
							got.dir_a !== want.dir_a || got.dir_b !== want.dir_b ||
							got.half_period_us !== want.half_period_us ||
							got.completed_steps !== want.completed_steps ||
							got.done_res !== want.done_res || got.aborted !== want.aborted) begin
						if (errors < 10)
							$display("%0t: mismatch expected %p actual %p", $time, want, got);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

// ===== dv/tb_corexy_accel_step_generator_core.sv =====
`timescale 1ns / 100ps
// Testbench top: clock, reset, register phases, step word stimulus and the verdict.
module tb_corexy_accel_step_generator_core;
	import cxs_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          errors, pending;
	int          sent, res_seen;
	bit          hold_done;

	cxs_item_if step_in ();
	cxs_res_if  res_out ();

	corexy_accel_step_generator_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_in (step_in),
		.res_out (res_out),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	cxs_step_checker u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_in (step_in),
		.res_out (res_out),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.pready  (pready),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	initial begin
		#60ms;
		$display("FAIL");
		$finish;
	end

	// result side: random stalls, one quiet stretch, one long hold-off
	initial begin
		res_out.ready = 1'b0;
		res_seen      = 0;
		hold_done     = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (res_out.valid && res_out.ready) res_seen++;
			if (!hold_done && res_seen == 400) begin
				hold_done = 1;
				res_out.ready <= 1'b0;
				repeat (1500) @(posedge clk);
			end else if (res_seen >= 700 && res_seen < 1000) begin
				res_out.ready <= 1'b1;
			end else begin
				res_out.ready <= ($urandom_range(99) >= 28);
			end
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// drop valid and wait until every expected result has come back
	task automatic drain();
		@(posedge clk);
		step_in.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
	endtask

	task automatic set_regs(input logic [15:0] f, input logic [15:0] s, input logic [16:0] a);
		drain();
		reg_write(REG_FAST, 32'(f));
		reg_write(REG_START, 32'(s));
		reg_write(REG_ACCEL, 32'(a));
	endtask

	task automatic send_word(input logic cmd, input logic [17:0] as, input logic [17:0] bs,
			input logic restart, input logic [23:0] total, input logic abort);
		if (!(sent >= 600 && sent < 900) && $urandom_range(99) < 28) begin
			step_in.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		step_in.valid           <= 1'b1;
		step_in.cmd             <= cmd;
		step_in.a_steps         <= as;
		step_in.b_steps         <= bs;
		step_in.restart_profile <= restart;
		step_in.profile_total   <= total;
		step_in.abort           <= abort;
		@(posedge clk);
		while (!step_in.ready) @(posedge clk);
		sent++;
	endtask

	task automatic load_move(input logic [17:0] as, input logic [17:0] bs,
			input logic restart, input logic [23:0] total);
		send_word(1'b0, as, bs, restart, total, 1'b0);
	endtask

	task automatic step_move(input logic abort);
		send_word(1'b1, 18'($urandom), 18'($urandom), $urandom_range(1), 24'($urandom), abort);
	endtask

	function automatic logic [17:0] small_count();
		int m;
		m = $urandom_range(0, 60);
		return $urandom_range(1) ? 18'(-m) : 18'(m);
	endfunction

	initial begin
		int n_steps, mag_a, mag_b, len;
		logic [17:0] as, bs;
		arst_n                  = 1'b0;
		psel                    = 1'b0;
		penable                 = 1'b0;
		pwrite                  = 1'b0;
		paddr                   = '0;
		pwdata                  = '0;
		step_in.valid           = 1'b0;
		step_in.cmd             = 1'b0;
		step_in.a_steps         = '0;
		step_in.b_steps         = '0;
		step_in.restart_profile = 1'b0;
		step_in.profile_total   = '0;
		step_in.abort           = 1'b0;
		sent                    = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle step and idle abort, extremes of counts and profile
		step_move(1'b0);
		send_word(1'b1, '0, '0, 1'b0, '0, 1'b1);
		load_move(18'h20000, 18'h1FFFF, 1'b1, 24'hFFFFFF);
		step_move(1'b0);
		step_move(1'b0);
		step_move(1'b1);
		step_move(1'b0);
		load_move('0, '0, 1'b1, 24'd5);
		step_move(1'b0);
		load_move(18'd3, -18'sd2, 1'b1, '0);
		repeat (4) step_move(1'b0);
		load_move(-18'sd4, 18'd4, 1'b0, '0);
		repeat (4) step_move(1'b0);
		load_move(18'd5, 18'd0, 1'b1, 24'd3);
		step_move(1'b0);
		load_move(18'd2, 18'd7, 1'b1, 24'd1);
		repeat (3) step_move(1'b0);

		// register extremes, zero delays, fast above start
		set_regs(16'd1, 16'd65535, 17'd100000);
		load_move(18'd6, -18'sd9, 1'b1, 24'd8);
		repeat (9) step_move(1'b0);
		set_regs(16'd65535, 16'd1, 17'd8000);
		load_move(18'd3, 18'd3, 1'b1, 24'd4);
		repeat (3) step_move(1'b0);
		set_regs(16'd0, 16'd0, 17'd8000);
		load_move(18'd2, 18'd1, 1'b1, 24'd2);
		repeat (2) step_move(1'b0);
		set_regs(FAST_RST, START_RST, ACCEL_RST);

		// random moves with occasional noise and register phases
		while (sent < 1950) begin
			if (sent >= 1200 && sent < 1215) drain();
			if (sent % 450 < 12 && sent > 100)
				set_regs(16'($urandom_range(1, 400)), 16'($urandom_range(200, 65535)),
					17'($urandom_range(8000, 100000)));
			if ($urandom_range(99) < 8) begin
				step_move($urandom_range(1));
				continue;
			end
			case ($urandom_range(9))
				0, 1:    begin as = 18'($urandom); bs = 18'($urandom); end
				2:       begin as = small_count(); bs = '0; end
				default: begin as = small_count(); bs = small_count(); end
			endcase
			mag_a = as[17] ? 262144 - as : as;
			mag_b = bs[17] ? 262144 - bs : bs;
			len   = (mag_a > mag_b) ? mag_a : mag_b;
			load_move(as, bs, $urandom_range(3) != 0,
				($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 200)));
			n_steps = (len <= 80) ? len + $urandom_range(0, 2) : $urandom_range(5, 40);
			for (int i = 0; i < n_steps; i++)
				step_move($urandom_range(99) < 3);
		end
		drain();
		repeat (220) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/cxs_pkg.sv
hdl/cxs_ifs.sv
hdl/cxs_ctrl.sv
hdl/cxs_dp.sv
hdl/corexy_accel_step_generator_core.sv
dv/cxs_step_checker.sv
dv/tb_corexy_accel_step_generator_core.sv
